FILE: hw/rtl/kmer_rolling_poly_hash_core_macros.svh
// Assertion macros for the k-mer rolling hash core.
// Included by the modules that carry assertions; no other dependencies.
`ifndef KMER_ROLLING_POLY_HASH_CORE_MACROS_SVH
`define KMER_ROLLING_POLY_HASH_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define KRPH_ASSERT(lbl, prop) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	prop) else $error("kmer hash core assertion failed");
`define KRPH_NEVER(lbl, cond) `KRPH_ASSERT(lbl, !(cond))
`else
`define KRPH_ASSERT(lbl, prop)
`define KRPH_NEVER(lbl, cond)
`endif
`endif

FILE: hw/rtl/kmer_hash_pkg.sv
// Shared constants, types and modular helpers for the k-mer rolling hash core.
// No dependencies.
`default_nettype none
package kmer_hash_pkg;

	localparam int MOD_BITS  = 41;
	localparam int MAX_K     = 64;
	localparam int K_BITS    = $clog2(MAX_K + 1);
	localparam int HEAD_BITS = $clog2(MAX_K);
	localparam int CNT_BITS  = $clog2(MOD_BITS);

	typedef logic [MOD_BITS-1:0] word_t;
	typedef logic [2:0]          code_t;
	typedef logic [3:0]          op_t;

	localparam code_t CODE_N = 3'd4;

	// register indexes
	localparam logic [2:0] REG_MODULUS    = 3'd0;
	localparam logic [2:0] REG_BASE       = 3'd1;
	localparam logic [2:0] REG_WINDOW_LEN = 3'd2;
	localparam logic [2:0] REG_BASE_POW_K = 3'd3;
	localparam logic [2:0] REG_INV_BASE   = 3'd4;

	localparam word_t RST_MODULUS  = 41'd1099000000003;
	localparam word_t RST_BASE     = 41'd31;
	localparam logic [K_BITS-1:0] RST_WINDOW_LEN = K_BITS'(1);
	localparam word_t RST_POW_K    = 41'd31;
	localparam word_t RST_INV_BASE = 41'd106354838710;

	// sequencer steps, run in this order
	localparam op_t OP_RED_P = 4'd0;
	localparam op_t OP_RED_K = 4'd1;
	localparam op_t OP_RED_I = 4'd2;
	localparam op_t OP_RED_F = 4'd3;
	localparam op_t OP_RED_R = 4'd4;
	localparam op_t OP_MUL_F = 4'd5;
	localparam op_t OP_ADD_F = 4'd6;
	localparam op_t OP_MUL_O = 4'd7;
	localparam op_t OP_SUB_F = 4'd8;
	localparam op_t OP_SUB_R = 4'd9;
	localparam op_t OP_MUL_I = 4'd10;
	localparam op_t OP_ADD_R = 4'd11;
	localparam op_t OP_MUL_R = 4'd12;

	typedef struct packed {
		logic load;
		logic start;
		logic exec;
		logic emit;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic mul_done;
		logic mul_busy;
	} sts_t;

	function automatic word_t mod_add(input word_t a, input word_t b, input word_t m);
		logic [MOD_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, m}) s = s - {1'b0, m};
		return s[MOD_BITS-1:0];
	endfunction

	function automatic word_t mod_sub(input word_t a, input word_t b, input word_t m);
		word_t r;
		if (a >= b) r = a - b;
		else r = a + (m - b);
		return r;
	endfunction

	function automatic code_t complement(input code_t c);
		code_t r;
		r = (c < CODE_N) ? 3'd3 - c : CODE_N;
		return r;
	endfunction

	function automatic code_t code_value(input code_t c);
		code_t r;
		case (c)
			3'd0: r = 3'd1;
			3'd1: r = 3'd2;
			3'd2: r = 3'd3;
			3'd3: r = 3'd4;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	// value of 0..4 reduced by a modulus of at least one
	function automatic word_t small_mod(input code_t v, input word_t m);
		word_t r;
		r = word_t'(v);
		for (int i = 0; i < 4; i++) begin
			if (r >= m) r = r - m;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/kmer_hash_mmul.sv
// Bit-serial modular multiplier, one multiplier bit per cycle, MSB first.
// Depends on kmer_hash_pkg.
`default_nettype none
module kmer_hash_mmul (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire kmer_hash_pkg::word_t  a,
	input  wire kmer_hash_pkg::word_t  b,
	input  wire kmer_hash_pkg::word_t  m,
	output logic                       busy,
	output logic                       done,
	output kmer_hash_pkg::word_t       result
);
	import kmer_hash_pkg::*;

	word_t                 acc_q;
	word_t                 a_q;
	word_t                 b_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  busy_q;
	logic                  done_q;
	word_t                 dbl;
	word_t                 nxt;

	// double, then add the multiplicand when the current bit is set
	always_comb begin
		dbl = mod_add(acc_q, acc_q, m);
		nxt = b_q[MOD_BITS-1] ? mod_add(dbl, a_q, m) : dbl;
	end

	// control: bit counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(MOD_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: accumulator and shifting multiplier
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			a_q   <= a;
			b_q   <= b;
		end else if (busy_q) begin
			acc_q <= nxt;
			b_q   <= {b_q[MOD_BITS-2:0], 1'b0};
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign result = acc_q;
endmodule
`default_nettype wire

FILE: hw/rtl/kmer_hash_dp.sv
// Datapath: configuration registers, nucleotide window, hash accumulators,
// operand selection for the shared modular multiplier. Depends on kmer_hash_pkg.
`default_nettype none
module kmer_hash_dp (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [2:0]            cfg_index,
	input  wire kmer_hash_pkg::word_t  cfg_data,
	input  wire kmer_hash_pkg::code_t  nucleotide,
	input  wire logic                  restart,
	input  wire kmer_hash_pkg::cmd_t   cmd,
	output kmer_hash_pkg::sts_t        sts,
	output kmer_hash_pkg::word_t       forward_hash,
	output kmer_hash_pkg::word_t       reverse_hash
);
	import kmer_hash_pkg::*;

	word_t                 modulus_q;
	word_t                 base_q;
	logic [K_BITS-1:0]     wl_q;
	word_t                 pow_k_q;
	word_t                 inv_base_q;

	logic [2:0]            win_mem [MAX_K];
	logic [MAX_K-1:0]      win_vld_q;
	logic [HEAD_BITS-1:0]  head_q;
	code_t                 rd_code_q;
	logic                  rd_vld_q;
	code_t                 cin_q;

	word_t                 p_q;
	word_t                 pk_q;
	word_t                 ip_q;
	word_t                 t_q;
	word_t                 fwd_q;
	word_t                 rev_q;
	word_t                 fwd_out_q;
	word_t                 rev_out_q;

	word_t                 m_eff;
	logic [K_BITS-1:0]     k_eff;
	logic [HEAD_BITS-1:0]  head_eff;
	logic [HEAD_BITS-1:0]  slot;
	code_t                 cin;
	code_t                 cout;
	word_t                 vin;
	word_t                 vcin;
	word_t                 vout;
	word_t                 vcout;
	word_t                 mm_a;
	word_t                 mm_b;
	word_t                 mm_res;
	logic                  mm_busy;
	logic                  mm_done;

	// effective modulus, window length and window addresses
	always_comb begin
		m_eff    = (modulus_q == '0) ? word_t'(1) : modulus_q;
		k_eff    = (wl_q == '0) ? K_BITS'(1) : wl_q;
		head_eff = restart ? '0 : head_q;
		slot     = head_eff - k_eff[HEAD_BITS-1:0];
		cin      = (nucleotide > CODE_N) ? CODE_N : nucleotide;
		cout     = rd_vld_q ? rd_code_q : CODE_N;
		vin      = small_mod(code_value(cin_q), m_eff);
		vcin     = small_mod(code_value(complement(cin_q)), m_eff);
		vout     = small_mod(code_value(cout), m_eff);
		vcout    = small_mod(code_value(complement(cout)), m_eff);
	end

	// configuration writes; saturate the window length on entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q  <= RST_MODULUS;
			base_q     <= RST_BASE;
			wl_q       <= RST_WINDOW_LEN;
			pow_k_q    <= RST_POW_K;
			inv_base_q <= RST_INV_BASE;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MODULUS:    modulus_q <= cfg_data;
				REG_BASE:       base_q    <= cfg_data;
				REG_WINDOW_LEN: begin
					if (cfg_data > word_t'(MAX_K)) wl_q <= K_BITS'(MAX_K);
					else wl_q <= cfg_data[K_BITS-1:0];
				end
				REG_BASE_POW_K: pow_k_q    <= cfg_data;
				REG_INV_BASE:   inv_base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// window store: read the leaving code, write the new one
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			win_mem[head_eff] <= cin;
			rd_code_q         <= win_mem[slot];
			cin_q             <= cin;
		end
	end

	// window valid bits and head; restart empties the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_vld_q <= '0;
			head_q    <= '0;
			rd_vld_q  <= 1'b0;
		end else if (cmd.load) begin
			rd_vld_q  <= restart ? 1'b0 : win_vld_q[slot];
			win_vld_q <= (restart ? '0 : win_vld_q) | (MAX_K'(1) << head_eff);
			head_q    <= head_eff + 1'b1;
		end
	end

	// multiplier operand select
	always_comb begin
		mm_a = word_t'(1);
		mm_b = base_q;
		case (cmd.op)
			OP_RED_P: mm_b = base_q;
			OP_RED_K: mm_b = pow_k_q;
			OP_RED_I: mm_b = inv_base_q;
			OP_RED_F: mm_b = fwd_q;
			OP_RED_R: mm_b = rev_q;
			OP_MUL_F: begin
				mm_a = fwd_q;
				mm_b = p_q;
			end
			OP_MUL_O: begin
				mm_a = vout;
				mm_b = pk_q;
			end
			OP_MUL_I: begin
				mm_a = vcin;
				mm_b = pk_q;
			end
			OP_MUL_R: begin
				mm_a = rev_q;
				mm_b = ip_q;
			end
			default: ;
		endcase
	end

	kmer_hash_mmul u_mmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.a      (mm_a),
		.b      (mm_b),
		.m      (m_eff),
		.busy   (mm_busy),
		.done   (mm_done),
		.result (mm_res)
	);

	// reduced operands and temporary
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			case (cmd.op)
				OP_RED_P: p_q  <= mm_res;
				OP_RED_K: pk_q <= mm_res;
				OP_RED_I: ip_q <= mm_res;
				OP_MUL_O: t_q  <= mm_res;
				OP_MUL_I: t_q  <= mm_res;
				default: ;
			endcase
		end
	end

	// hash accumulators: clear on restart, update per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= '0;
			rev_q <= '0;
		end else if (cmd.load) begin
			if (restart) begin
				fwd_q <= '0;
				rev_q <= '0;
			end
		end else if (cmd.exec) begin
			case (cmd.op)
				OP_RED_F: fwd_q <= mm_res;
				OP_RED_R: rev_q <= mm_res;
				OP_MUL_F: fwd_q <= mm_res;
				OP_ADD_F: fwd_q <= mod_add(fwd_q, vin, m_eff);
				OP_SUB_F: fwd_q <= mod_sub(fwd_q, t_q, m_eff);
				OP_SUB_R: rev_q <= mod_sub(rev_q, vcout, m_eff);
				OP_ADD_R: rev_q <= mod_add(rev_q, t_q, m_eff);
				OP_MUL_R: rev_q <= mm_res;
				default: ;
			endcase
		end
	end

	// output register, loaded when the result is handed off
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			fwd_out_q <= fwd_q;
			rev_out_q <= rev_q;
		end
	end

	assign sts.mul_done = mm_done;
	assign sts.mul_busy = mm_busy;
	assign forward_hash = fwd_out_q;
	assign reverse_hash = rev_out_q;
endmodule
`default_nettype wire

FILE: hw/rtl/kmer_hash_ctrl.sv
// Controller: accepts a request, steps the datapath through its operation
// sequence and hands the result to the output register. Depends on kmer_hash_pkg.
`default_nettype none
`include "kmer_rolling_poly_hash_core_macros.svh"
module kmer_hash_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire kmer_hash_pkg::sts_t  sts,
	output kmer_hash_pkg::cmd_t       cmd
);
	import kmer_hash_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0] state_q;
	op_t        op_q;
	logic       issued_q;
	logic       out_valid_q;
	logic       is_mul;

	// decode the current step into commands
	always_comb begin
		is_mul    = op_q inside {OP_RED_P, OP_RED_K, OP_RED_I, OP_RED_F, OP_RED_R,
			OP_MUL_F, OP_MUL_O, OP_MUL_I, OP_MUL_R};
		in_ready  = (state_q == ST_IDLE);
		cmd.load  = in_valid && in_ready;
		cmd.op    = op_q;
		cmd.start = (state_q == ST_RUN) && is_mul && !issued_q;
		cmd.exec  = (state_q == ST_RUN) && (is_mul ? (issued_q && sts.mul_done) : 1'b1);
		cmd.emit  = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	end

	// sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= OP_RED_P;
			issued_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_RUN;
						op_q    <= OP_RED_P;
					end
				end
				ST_RUN: begin
					if (cmd.start) issued_q <= 1'b1;
					if (cmd.exec) begin
						issued_q <= 1'b0;
						if (op_q == OP_MUL_R) state_q <= ST_OUT;
						else op_q <= op_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (cmd.emit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// hold the result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`KRPH_ASSERT(a_done_after_issue, (state_q == ST_RUN && sts.mul_done) |-> issued_q)
	`KRPH_NEVER(a_start_while_busy, cmd.start && sts.mul_busy)
	`KRPH_ASSERT(a_emit_slot_free, cmd.emit |-> (!out_valid_q || out_ready))
	`KRPH_ASSERT(a_accept_runs, cmd.load |=> (state_q == ST_RUN && op_q == OP_RED_P))
endmodule
`default_nettype wire

FILE: hw/rtl/kmer_rolling_poly_hash_core.sv
// From accepted request to result valid: nine modular multiply passes on the
// shared bit-serial multiplier (issue, one step per bit of the 41-bit multiplier
// and write-back), four add/subtract steps and the output load.
// A new request is taken only when idle, after the result is loaded to the output register.
// Reset (arst_n low): registers to defaults, hash accumulators zero, window all N.
`default_nettype none
module kmer_rolling_poly_hash_core (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [2:0]            cfg_index,
	input  wire kmer_hash_pkg::word_t  cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire kmer_hash_pkg::code_t  nucleotide,
	input  wire logic                  restart,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output kmer_hash_pkg::word_t       forward_hash,
	output kmer_hash_pkg::word_t       reverse_hash
);
	import kmer_hash_pkg::*;

	cmd_t cmd;
	sts_t sts;

	kmer_hash_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kmer_hash_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.nucleotide   (nucleotide),
		.restart      (restart),
		.cmd          (cmd),
		.sts          (sts),
		.forward_hash (forward_hash),
		.reverse_hash (reverse_hash)
	);
endmodule
`default_nettype wire

FILE: bench/kmer_rolling_poly_hash_core_test.sv
// Self-checking bench for kmer_rolling_poly_hash_core: forward and reverse-complement
// rolling hashes predicted in-bench and compared per result. Depends on kmer_hash_pkg.
`timescale 1ns / 100ps
`default_nettype none
module kmer_rolling_poly_hash_core_test;
	import kmer_hash_pkg::*;

	localparam int HOLD_CYCLES = 3000;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		code_t nuc;
		logic  rst;
	} base_req_t;

	typedef struct {
		word_t fwd;
		word_t rev;
	} hash_pair_t;

	logic clk, arst_n;
	logic cfg_wr_en;
	logic [2:0] cfg_index;
	word_t cfg_data;
	logic in_valid, in_ready, out_valid, out_ready;
	code_t nucleotide;
	logic restart;
	word_t forward_hash, reverse_hash;

	kmer_rolling_poly_hash_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.nucleotide(nucleotide), .restart(restart),
		.out_valid(out_valid), .out_ready(out_ready),
		.forward_hash(forward_hash), .reverse_hash(reverse_hash)
	);

	// bench copy of the registers and the rolling state
	word_t mdl_mod, mdl_base, mdl_pow, mdl_inv;
	word_t mdl_k;
	word_t fwd_acc, rev_acc;
	code_t win_codes [MAX_K];
	int win_head;

	base_req_t pending_bases [$];
	hash_pair_t expected_hashes [$];
	int errors, results_seen, bases_sent;
	int idle_pct, stall_pct;
	logic long_hold_go, in_took;

	always begin
		clk = 1'b0; #4;
		clk = 1'b1; #4;
	end

	function automatic word_t add_m(word_t a, word_t b, word_t m);
		logic [MOD_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, m}) s = s - {1'b0, m};
		return s[MOD_BITS-1:0];
	endfunction

	function automatic word_t sub_m(word_t a, word_t b, word_t m);
		return (a >= b) ? a - b : a + (m - b);
	endfunction

	function automatic word_t mul_m(word_t a, word_t b, word_t m);
		word_t r;
		r = '0;
		for (int i = MOD_BITS - 1; i >= 0; i--) begin
			r = add_m(r, r, m);
			if (b[i]) r = add_m(r, a, m);
		end
		return r;
	endfunction

	function automatic word_t weight(code_t c);
		case (c)
			3'd0: return 1;
			3'd1: return 2;
			3'd2: return 3;
			3'd3: return 4;
			default: return 0;
		endcase
	endfunction

	function automatic code_t revcomp(code_t c);
		return (c < CODE_N) ? 3'd3 - c : CODE_N;
	endfunction

	function automatic void clear_rolling();
		foreach (win_codes[i]) win_codes[i] = CODE_N;
		win_head = 0;
		fwd_acc = '0;
		rev_acc = '0;
	endfunction

	// roll one base into both hashes and queue the expected pair
	function automatic void roll_hashes(code_t nuc, logic rst);
		word_t m, p, pk, ip, f, r;
		int k;
		code_t c_in, c_out;
		hash_pair_t h;
		m = (mdl_mod == 0) ? word_t'(1) : mdl_mod;
		p = mdl_base % m;
		pk = mdl_pow % m;
		ip = mdl_inv % m;
		if (mdl_k == 0) k = 1;
		else if (mdl_k > word_t'(MAX_K)) k = MAX_K;
		else k = int'(mdl_k);
		c_in = (nuc > CODE_N) ? CODE_N : nuc;
		if (rst) clear_rolling();
		c_out = win_codes[(win_head + MAX_K - k) % MAX_K];
		win_codes[win_head] = c_in;
		win_head = (win_head + 1) % MAX_K;
		f = fwd_acc % m;
		f = add_m(mul_m(f, p, m), weight(c_in) % m, m);
		f = sub_m(f, mul_m(weight(c_out) % m, pk, m), m);
		fwd_acc = f;
		r = rev_acc % m;
		r = sub_m(r, weight(revcomp(c_out)) % m, m);
		r = add_m(r, mul_m(weight(revcomp(c_in)) % m, pk, m), m);
		r = mul_m(r, ip, m);
		rev_acc = r;
		h.fwd = f;
		h.rev = r;
		expected_hashes.push_back(h);
	endfunction

	task automatic write_reg(logic [2:0] idx, word_t val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_MODULUS:    mdl_mod = val;
			REG_BASE:       mdl_base = val;
			REG_WINDOW_LEN: mdl_k = val;
			REG_BASE_POW_K: mdl_pow = val;
			REG_INV_BASE:   mdl_inv = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic program_all(word_t m, word_t p, logic [6:0] k, word_t pk, word_t ip);
		write_reg(REG_MODULUS, m);
		write_reg(REG_BASE, p);
		write_reg(REG_WINDOW_LEN, {34'd0, k});
		write_reg(REG_BASE_POW_K, pk);
		write_reg(REG_INV_BASE, ip);
	endtask

	function automatic word_t rand_word();
		return {9'($urandom_range(511)), $urandom()};
	endfunction

	task automatic push_base(code_t nuc, logic rst);
		base_req_t b;
		b.nuc = nuc;
		b.rst = rst;
		pending_bases.push_back(b);
	endtask

	// mostly clean A/C/G/T runs, some N and out-of-range codes, rare restarts
	task automatic push_random(int n);
		for (int i = 0; i < n; i++)
			push_base(($urandom_range(9) == 0) ? code_t'($urandom_range(7))
				: code_t'($urandom_range(3)), $urandom_range(39) == 0);
	endtask

	// wait until the block has nothing queued or in flight
	task automatic drain();
		while (pending_bases.size() != 0 || in_valid || expected_hashes.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// driver: hold an offered request until taken, then maybe idle
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !in_took)) begin
			if (pending_bases.size() != 0 && $urandom_range(99) >= idle_pct) begin
				in_valid <= 1'b1;
				nucleotide <= pending_bases[0].nuc;
				restart <= pending_bases[0].rst;
				void'(pending_bases.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus one long hold-off
	int hold_left = 0;
	logic hold_done = 1'b0;
	always @(negedge clk) begin
		if (long_hold_go && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// predict on accept, check on result
	always @(posedge clk) begin
		in_took = in_valid && in_ready;
		if (arst_n && in_took) begin
			roll_hashes(nucleotide, restart);
			bases_sent++;
		end
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_hashes.size() == 0) begin
				$error("unexpected result: forward_hash %0d reverse_hash %0d",
					forward_hash, reverse_hash);
				errors++;
			end else begin
				if (forward_hash !== expected_hashes[0].fwd) begin
					$error("forward_hash expected %0d actual %0d",
						expected_hashes[0].fwd, forward_hash);
					errors++;
				end
				if (reverse_hash !== expected_hashes[0].rev) begin
					$error("reverse_hash expected %0d actual %0d",
						expected_hashes[0].rev, reverse_hash);
					errors++;
				end
				void'(expected_hashes.pop_front());
			end
		end
	end

	// watchdog on handshake inactivity
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("kmer_rolling_poly_hash_core_test: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		nucleotide = '0;
		restart = 1'b0;
		in_took = 1'b0;
		long_hold_go = 1'b0;
		errors = 0;
		results_seen = 0;
		bases_sent = 0;
		idle_pct = 0;
		stall_pct = 0;
		mdl_mod = RST_MODULUS;
		mdl_base = RST_BASE;
		mdl_k = word_t'(1);
		mdl_pow = RST_POW_K;
		mdl_inv = RST_INV_BASE;
		clear_rolling();
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed: every code including out-of-range ones, restarts, at reset settings
		for (int c = 0; c < 8; c++) push_base(code_t'(c), 1'b0);
		push_base(3'd2, 1'b1);
		push_base(3'd7, 1'b1);
		drain();
		// tiny modulus, window of three
		program_all(41'd3, 41'd2, 7'd3, 41'd2, 41'd2);
		for (int c = 0; c < 5; c++) push_base(code_t'(c), 1'b0);
		drain();
		// largest modulus and base, full window
		program_all({MOD_BITS{1'b1}}, {{(MOD_BITS-1){1'b1}}, 1'b0}, 7'd64,
			rand_word(), rand_word());
		push_base(3'd3, 1'b1);
		push_random(6);
		drain();
		// modulus zero; then zero window length with registers above the modulus
		write_reg(REG_MODULUS, 41'd0);
		push_base(3'd1, 1'b0);
		drain();
		program_all(41'd1000003, {MOD_BITS{1'b1}}, 7'd0, {MOD_BITS{1'b1}}, 41'd0);
		push_base(3'd0, 1'b0);
		drain();
		// window beyond the maximum; writes to unused indexes are ignored
		write_reg(REG_WINDOW_LEN, 41'd100);
		write_reg(3'd5, rand_word());
		write_reg(3'd6, rand_word());
		write_reg(3'd7, rand_word());
		push_base(3'd2, 1'b0);
		push_base(3'd4, 1'b0);
		drain();

		// random phases: free flow, sender idle, receiver stalling, both
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1 || ph == 3) ? 63 : ((ph == 3) ? 16 : 0);
			stall_pct = (ph == 2) ? 63 : 0;
			if (ph == 3) begin
				idle_pct = 16;
				stall_pct = 16;
			end
			program_all(($urandom_range(3) == 0) ? word_t'($urandom_range(1000, 3))
				: rand_word(), rand_word(), 7'($urandom_range(64, 1)),
				rand_word(), rand_word());
			push_base(code_t'($urandom_range(3)), 1'b1);
			push_random(320);
			if (ph == 0) long_hold_go = 1'b1;
			drain();
		end

		repeat (400) @(posedge clk);
		if (expected_hashes.size() != 0) begin
			$error("%0d expected results never arrived", expected_hashes.size());
			errors++;
		end
		$display("Sent %0d bases and checked %0d hash pairs over %0s", bases_sent,
			results_seen, "extreme moduli, window lengths and four flow-control mixes");
		if (errors == 0) begin
			$display("kmer_rolling_poly_hash_core_test: clean");
		end else begin
			$display("kmer_rolling_poly_hash_core_test: errors");
		end
		$finish;
	end

endmodule
`default_nettype wire

FILE: files.f
+incdir+hw/rtl
hw/rtl/kmer_hash_pkg.sv
hw/rtl/kmer_hash_mmul.sv
hw/rtl/kmer_hash_dp.sv
hw/rtl/kmer_hash_ctrl.sv
hw/rtl/kmer_rolling_poly_hash_core.sv
bench/kmer_rolling_poly_hash_core_test.sv
